FILE: sv/base64_stream_encoder_macros.svh
// Assertion shorthands used by the checker of this block.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define B64_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64 assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define B64_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64 assertion failed: next-cycle implication");

`endif

FILE: sv/b64_pkg.sv
`default_nettype none
package b64_pkg;

   localparam int BYTE_W  = 8;
   localparam int CHAR_W  = 7;
   localparam int SYM_W   = 6;
   localparam int LEFT_W  = 4;
   localparam int SLOTS   = 4;
   localparam int SLOT_W  = 2;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

   // position of the next byte within its three-byte group
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   typedef logic [CHAR_W-1:0] char_type;

   // one decoded byte: up to four characters and the index of the last one
   typedef struct packed {
      char_type [SLOTS-1:0] chars;
      logic [SLOT_W-1:0]    last_slot;
      logic                 eom;
   } job_type;

   // queue status seen by the front and back ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic char_type b64_char(input logic [SYM_W-1:0] v);
      char_type c;
      if (v < 6'd26) begin
         c = 7'd65 + {1'b0, v};
      end else if (v < 6'd52) begin
         c = 7'd71 + {1'b0, v};
      end else if (v < 6'd62) begin
         c = {1'b0, v} - 7'd4;
      end else if (v == 6'd62) begin
         c = 7'd43;
      end else begin
         c = 7'd47;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: sv/b64_if.sv
`default_nettype none
interface b64_req_if import b64_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64_rsp_if import b64_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              run_last;
   logic              message_done;

   modport source (output valid, output out_char, output run_last, output message_done,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input message_done,
                   output ready);
endinterface
`default_nettype wire

FILE: sv/b64_front.sv
`default_nettype none
module b64_front import b64_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   b64_req_if.sink             req_port,
   input  wire queue_stat_type q_stat,
   output logic                push,
   output job_type             push_job
);

   logic [1:0]        phase_ff, phase_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [BYTE_W-1:0] b;
   logic              eom;

   assign b     = req_port.data_byte;
   assign eom   = req_port.end_of_message;
   assign req_port.ready = !q_stat.full;
   assign push  = req_port.valid && !q_stat.full;

   always_comb begin
      push_job.chars     = {SLOTS{PAD_CHAR}};
      push_job.last_slot = 2'd0;
      push_job.eom       = eom;
      phase_in           = PHASE_FIRST;
      left_in            = '0;
      unique case (phase_ff)
         PHASE_SECOND: begin
            push_job.chars[0] = b64_char({left_ff[1:0], b[7:4]});
            if (eom) begin
               push_job.chars[1]  = b64_char({b[3:0], 2'b00});
               push_job.last_slot = 2'd2;
            end else begin
               phase_in = PHASE_THIRD;
               left_in  = b[3:0];
            end
         end
         PHASE_THIRD: begin
            push_job.chars[0]  = b64_char({left_ff, b[7:6]});
            push_job.chars[1]  = b64_char(b[5:0]);
            push_job.last_slot = 2'd1;
         end
         default: begin
            // first byte of a group; the unused code behaves the same
            push_job.chars[0] = b64_char(b[7:2]);
            if (eom) begin
               push_job.chars[1]  = b64_char({b[1:0], 4'b0000});
               push_job.last_slot = 2'd3;
            end else begin
               phase_in = PHASE_SECOND;
               left_in  = {2'b00, b[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         left_ff  <= '0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/b64_queue.sv
`default_nettype none
module b64_queue import b64_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire job_type  push_job,
   input  wire logic     pop,
   output job_type       head_job,
   output queue_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type             store [DEPTH];
   logic [PTR_W-1:0]    wr_ff, rd_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                do_push, do_pop;

   assign q_stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_job     = store[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

FILE: sv/b64_back.sv
`default_nettype none
module b64_back import b64_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_stat_type q_stat,
   input  wire job_type        head_job,
   output logic                pop,
   b64_rsp_if.source           rsp_port
);

   logic [SLOT_W-1:0] slot_ff;
   logic              valid_ff;
   char_type          char_ff;
   logic              last_ff, done_ff;
   logic              load, take, at_last;

   assign load    = !valid_ff || rsp_port.ready;
   assign take    = load && !q_stat.empty;
   assign at_last = (slot_ff == head_job.last_slot);
   assign pop     = take && at_last;

   assign rsp_port.valid        = valid_ff;
   assign rsp_port.out_char     = char_ff;
   assign rsp_port.run_last     = last_ff;
   assign rsp_port.message_done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else if (load) begin
         valid_ff <= !q_stat.empty;
         if (take) begin
            slot_ff <= at_last ? '0 : slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= head_job.chars[slot_ff];
         last_ff <= at_last;
         done_ff <= at_last && head_job.eom;
      end
   end

endmodule
`default_nettype wire

FILE: sv/base64_stream_encoder.sv
// Streaming Base64 encoder, standard alphabet with '=' padding. Send one message
// byte per beat on req_port and flag the final byte with end_of_message; rsp_port
// returns one ASCII character per beat. Each byte yields one, one, then two
// characters across a three-byte group; a final byte flushes its leftover bits
// and pads so that every message encodes to a multiple of four characters.
// run_last marks the last character of each byte, message_done the last
// character of the message. The front end accepts a byte in any cycle the job
// queue has room and turns it into a job of up to four characters; the back end
// drains jobs one character per cycle, while the output is not stalled, into a
// registered output. The output port's one character per cycle sets the rate:
// one, one, then two characters across a group in the middle of a message (four
// characters per three bytes, never more than two for one byte) and three or four
// for a padded final byte. An accepted byte is written to the job queue and from
// there to the registered output character.
// QUEUE_DEPTH (two or more) sets how many decoded bytes may wait between the
// two ends. No clearing pass after reset.
`default_nettype none
module base64_stream_encoder import b64_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   b64_req_if.sink   req_port,
   b64_rsp_if.source rsp_port
);

   queue_stat_type q_stat;
   job_type        push_job;
   job_type        head_job;
   logic           push;
   logic           pop;

   // classify the byte by group phase and build its characters
   b64_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .q_stat   (q_stat),
      .push     (push),
      .push_job (push_job)
   );

   // hold decoded bytes so either side may stall on its own
   b64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   // advance one character per beat; drop the job after its last one
   b64_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .head_job (head_job),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

endmodule
`default_nettype wire

FILE: sv/b64_checker.sv
`default_nettype none
`include "base64_stream_encoder_macros.svh"
module b64_checker import b64_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [CHAR_W-1:0] out_char,
   input wire logic              run_last,
   input wire logic              message_done
);

   logic              legal_char;
   logic              pad_closes;
   logic [CHAR_W+1:0] rsp_beat;

   assign legal_char = (out_char >= 7'd65 && out_char <= 7'd90)
                    || (out_char >= 7'd97 && out_char <= 7'd122)
                    || (out_char >= 7'd48 && out_char <= 7'd57)
                    || (out_char == 7'd43) || (out_char == 7'd47) || (out_char == PAD_CHAR);
   assign pad_closes = rsp_valid && run_last && (out_char == PAD_CHAR);
   assign rsp_beat   = {out_char, run_last, message_done};

   // stalled beat holds
   `B64_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_beat))
   `B64_ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_valid && message_done, run_last)
   `B64_ASSERT_IMPLY(a_char_legal, clock, reset, rsp_valid, legal_char)
   // padding closes a byte only at the end of a message
   `B64_ASSERT_IMPLY(a_pad_at_end, clock, reset, pad_closes, message_done)

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_port.valid),
   .rsp_ready    (rsp_port.ready),
   .out_char     (rsp_port.out_char),
   .run_last     (rsp_port.run_last),
   .message_done (rsp_port.message_done)
);
`default_nettype wire
